### src/hkrd_pkg.sv
// ----------------------------------------------------------------------------
// hkrd_pkg: shared types and constants of the boot-keyboard report decoder
// Word layouts, the job passed from classifier to sequencer, and the US
// keyboard character map.
// ----------------------------------------------------------------------------
package hkrd_pkg;

    localparam int KEY_SLOT_COUNT = 6;
    localparam int EVENT_COUNT    = 2 * KEY_SLOT_COUNT;

    localparam logic [7:0] SHIFT_LEFT_BIT  = 8'h02;
    localparam logic [7:0] SHIFT_RIGHT_BIT = 8'h20;
    localparam logic [7:0] FIRST_KEY_CODE  = 8'd4;

    localparam logic EVENT_PRESS   = 1'b0;
    localparam logic EVENT_RELEASE = 1'b1;

    typedef logic [KEY_SLOT_COUNT-1:0][7:0] key_slots_t;
    typedef logic [KEY_SLOT_COUNT-1:0][6:0] key_chars_t;

    typedef struct packed {
        logic [7:0] modifiers;
        logic [7:0] key_0;
        logic [7:0] key_1;
        logic [7:0] key_2;
        logic [7:0] key_3;
        logic [7:0] key_4;
        logic [7:0] key_5;
    } report_word_t;

    typedef struct packed {
        logic       event_kind;
        logic [7:0] key_code;
        logic [6:0] ascii_char;
        logic [7:0] modifier_bits;
        logic       last;
    } event_word_t;

    // Lower half of mask: releases of previous slots; upper half: presses.
    typedef struct packed {
        logic [7:0]             modifiers;
        key_slots_t             now_keys;
        key_slots_t             prev_keys;
        key_chars_t             chars;
        logic [EVENT_COUNT-1:0] mask;
    } job_t;

    function automatic logic [6:0] map_char(input logic [7:0] code, input logic shifted);
        logic [6:0] ch;
        logic [6:0] low7;
        low7 = code[6:0];
        ch   = 7'h00;
        if (code >= 8'd4 && code <= 8'd29)
        begin
            ch = shifted ? (low7 + 7'd61) : (low7 + 7'd93);
        end
        else if (code >= 8'd30 && code <= 8'd38)
        begin
            if (shifted)
            begin
                case (code)
                    8'd30:   ch = 7'h21;
                    8'd31:   ch = 7'h40;
                    8'd32:   ch = 7'h23;
                    8'd33:   ch = 7'h24;
                    8'd34:   ch = 7'h25;
                    8'd35:   ch = 7'h5E;
                    8'd36:   ch = 7'h26;
                    8'd37:   ch = 7'h2A;
                    8'd38:   ch = 7'h28;
                    default: ch = 7'h00;
                endcase
            end
            else
            begin
                ch = low7 + 7'd19;
            end
        end
        else
        begin
            case (code)
                8'd39:   ch = shifted ? 7'h29 : 7'h30;
                8'd40:   ch = 7'd10;
                8'd41:   ch = 7'd27;
                8'd42:   ch = 7'd127;
                8'd43:   ch = 7'd9;
                8'd44:   ch = 7'd32;
                8'd45:   ch = shifted ? 7'h5F : 7'h2D;
                8'd46:   ch = shifted ? 7'h2B : 7'h3D;
                8'd47:   ch = shifted ? 7'h7B : 7'h5B;
                8'd48:   ch = shifted ? 7'h7D : 7'h5D;
                8'd49:   ch = shifted ? 7'h7C : 7'h5C;
                8'd51:   ch = shifted ? 7'h3A : 7'h3B;
                8'd52:   ch = shifted ? 7'h22 : 7'h27;
                8'd53:   ch = shifted ? 7'h7E : 7'h60;
                8'd54:   ch = shifted ? 7'h3C : 7'h2C;
                8'd55:   ch = shifted ? 7'h3E : 7'h2E;
                8'd56:   ch = shifted ? 7'h3F : 7'h2F;
                default: ch = 7'h00;
            endcase
        end
        return ch;
    endfunction

endpackage

### src/hkrd_front.sv
// ----------------------------------------------------------------------------
// hkrd_front: report classifier
// Compares each report with the stored slots, builds the event mask and
// characters, queues a job when any event results, and stores the slots.
// ----------------------------------------------------------------------------
module hkrd_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_data,
    input  logic                 accept,
    input  hkrd_pkg::report_word_t report,
    output logic                 job_push,
    output hkrd_pkg::job_t       job
);

    localparam int N = hkrd_pkg::KEY_SLOT_COUNT;

    logic                 event_mode_reg;
    hkrd_pkg::key_slots_t prev_keys_reg;
    hkrd_pkg::key_slots_t prev_keys_next;
    hkrd_pkg::key_slots_t now_keys;
    hkrd_pkg::key_chars_t chars;
    logic [N-1:0]         rel_mask;
    logic [N-1:0]         press_mask;
    logic                 shifted;

    assign now_keys[0] = report.key_0;
    assign now_keys[1] = report.key_1;
    assign now_keys[2] = report.key_2;
    assign now_keys[3] = report.key_3;
    assign now_keys[4] = report.key_4;
    assign now_keys[5] = report.key_5;

    assign shifted = |(report.modifiers & (hkrd_pkg::SHIFT_LEFT_BIT |
                                           hkrd_pkg::SHIFT_RIGHT_BIT));

    // All-pairs compare of old and new slots; each pair independent.
    always_comb
    begin
        logic hit_now;
        logic hit_prev;
        for (int i = 0; i < N; i++)
        begin
            hit_now  = 1'b0;
            hit_prev = 1'b0;
            for (int j = 0; j < N; j++)
            begin
                hit_now  = hit_now  | (now_keys[j] == prev_keys_reg[i]);
                hit_prev = hit_prev | (prev_keys_reg[j] == now_keys[i]);
            end
            chars[i]      = hkrd_pkg::map_char(now_keys[i], shifted);
            rel_mask[i]   = event_mode_reg && !hit_now &&
                            (prev_keys_reg[i] >= hkrd_pkg::FIRST_KEY_CODE);
            press_mask[i] = !hit_prev && (now_keys[i] >= hkrd_pkg::FIRST_KEY_CODE) &&
                            (event_mode_reg || (chars[i] != 7'h00));
        end
    end

    assign job.modifiers = report.modifiers;
    assign job.now_keys  = now_keys;
    assign job.prev_keys = prev_keys_reg;
    assign job.chars     = chars;
    assign job.mask      = {press_mask, rel_mask};

    // Reports with no events leave no job behind.
    assign job_push = accept && (|job.mask);

    assign prev_keys_next = accept ? now_keys : prev_keys_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_keys_reg  <= '0;
            event_mode_reg <= 1'b0;
        end
        else
        begin
            prev_keys_reg <= prev_keys_next;
            if (cfg_we)
            begin
                event_mode_reg <= cfg_data;
            end
        end
    end

endmodule

### src/hkrd_queue.sv
// ----------------------------------------------------------------------------
// hkrd_queue: job queue
// Short first-in first-out buffer between classifier and sequencer.
// ----------------------------------------------------------------------------
module hkrd_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hkrd_pkg::job_t push_job,
    input  logic           pop,
    output logic           full,
    output logic           head_valid,
    output hkrd_pkg::job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hkrd_pkg::job_t   slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/hkrd_back.sv
// ----------------------------------------------------------------------------
// hkrd_back: event sequencer
// Walks the head job's event mask lowest bit first into the output register,
// one word per cycle while that register is empty or being popped.
// ----------------------------------------------------------------------------
module hkrd_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  hkrd_pkg::job_t        head_job,
    output logic                  job_pop,
    input  logic                  pop,
    output logic                  empty,
    output hkrd_pkg::event_word_t key_event
);

    localparam int N = hkrd_pkg::KEY_SLOT_COUNT;
    localparam int E = hkrd_pkg::EVENT_COUNT;

    logic [E-1:0]          done_reg;
    logic [E-1:0]          done_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    hkrd_pkg::event_word_t out_word_reg;
    logic [E-1:0]          remaining;
    logic [E-1:0]          pick;
    logic                  advance;
    hkrd_pkg::event_word_t ev;

    assign remaining = head_job.mask & ~done_reg;
    assign pick      = remaining & (~remaining + 1'b1);
    assign advance   = head_valid && (!out_valid_reg || pop);
    assign job_pop   = advance && ev.last;

    always_comb
    begin
        ev               = '0;
        ev.modifier_bits = head_job.modifiers;
        ev.last          = ((remaining & ~pick) == '0);
        for (int i = 0; i < N; i++)
        begin
            if (pick[i])
            begin
                ev.event_kind = ev.event_kind | hkrd_pkg::EVENT_RELEASE;
                ev.key_code   = ev.key_code | head_job.prev_keys[i];
            end
            if (pick[N + i])
            begin
                ev.event_kind = ev.event_kind | hkrd_pkg::EVENT_PRESS;
                ev.key_code   = ev.key_code | head_job.now_keys[i];
                ev.ascii_char = ev.ascii_char | head_job.chars[i];
            end
        end
    end

    always_comb
    begin
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            done_next      = ev.last ? '0 : (done_reg | pick);
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= ev;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign empty     = !out_valid_reg;
    assign key_event = out_word_reg;

endmodule

### src/hid_keyboard_report_decoder_unit.sv
// ----------------------------------------------------------------------------
// hid_keyboard_report_decoder_unit: boot-keyboard report decoder
// Turns boot-keyboard reports into key press / release words with US ASCII.
// ----------------------------------------------------------------------------
// Usage:
//  - Input queue: drive report and raise push; the word is taken on a clock
//    edge with push high and full low. The decoder compares it to the
//    previous report's slots in that same cycle and stores the new slots.
//  - Result queue: while empty is low, key_event holds the oldest word;
//    pop on a cycle with empty low takes it. last marks a report's final word.
//  - cfg_we/cfg_data set event mode (1: press and release, 0: presses of keys
//    with a character only). Write it only while the decoder is idle.
//  - A taken report is written into the job queue; the sequencer moves its
//    words from the queue head into the output register, one word per cycle
//    while that register is empty or popped. A report has at most 12 words;
//    reports with no words queue no job. A report enters every cycle as long
//    as the job queue (JOB_DEPTH entries) has room.
//  - Stall: with pop low the output word holds, the sequencer pauses, the
//    job queue fills and full rises; nothing is dropped.
//  - Reset: stored slots read as zero, event mode is off, queues are empty.
// ----------------------------------------------------------------------------
module hid_keyboard_report_decoder_unit
#(
    parameter int JOB_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_data,
    input  logic                  push,
    output logic                  full,
    input  hkrd_pkg::report_word_t report,
    output logic                  empty,
    input  logic                  pop,
    output hkrd_pkg::event_word_t key_event
);

    logic           accept;
    logic           job_push;
    hkrd_pkg::job_t job_in;
    logic           job_pop;
    logic           head_valid;
    hkrd_pkg::job_t head_job;

    // Input taken whenever the job queue has room.
    assign accept = push && !full;

    hkrd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .accept   (accept),
        .report   (report),
        .job_push (job_push),
        .job      (job_in)
    );

    hkrd_queue #(.DEPTH(JOB_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_job   (job_in),
        .pop        (job_pop),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    hkrd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .job_pop    (job_pop),
        .pop        (pop),
        .empty      (empty),
        .key_event  (key_event)
    );

endmodule

### src/hkrd_checker.sv
// ----------------------------------------------------------------------------
// hkrd_checker: port-level checks of the report decoder
// Watches the queue handshakes and result words from the ports only.
// ----------------------------------------------------------------------------
module hkrd_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  push,
    input logic                  full,
    input logic                  empty,
    input logic                  pop,
    input hkrd_pkg::event_word_t key_event
);

    // In the cycle after reset is seen low, both queues read empty.
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> (empty && !full))
        else $error("queues not empty during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(key_event)))
        else $error("result word changed while stalled");

    a_release_char: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && key_event.event_kind == hkrd_pkg::EVENT_RELEASE)
            |-> (key_event.ascii_char == 7'h00))
        else $error("release word carries a character");

    a_code_floor: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (key_event.key_code >= hkrd_pkg::FIRST_KEY_CODE))
        else $error("word for a reserved key code");

endmodule

bind hid_keyboard_report_decoder_unit hkrd_checker u_hkrd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .key_event (key_event)
);

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the boot-keyboard report decoder
// Reports go in through the push/full queue, key words come out through the
// empty/pop queue. Each accepted report runs through a bench-side decoder
// that keeps its own copy of the held slots and of event mode. The key words
// it yields are queued and compared field by field with what the block emits.
// Directed reports cover the key-map corners; random typing-like reports
// follow in both modes, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    // Run control
    localparam int CYCLE_LIMIT   = 400_000; // many times the slowest legal run
    localparam int IDLE_PCT      = 38;      // chance in 100 that a side idles
    localparam int SETTLE_CYCLES = 10;      // quiet cycles before a mode write
    localparam int TAIL_CYCLES   = 20;      // extra wait once nothing is due
    localparam int PRINT_CAP     = 40;      // mismatch lines kept on screen

    // What the report backlog holds: a report, a mode write, or a pause
    // until every outstanding word has come back.
    typedef enum logic [1:0] {
        KIND_REPORT,
        KIND_MODE,
        KIND_SETTLE
    } entry_kind_t;

    typedef struct {
        entry_kind_t            kind;
        logic                   mode;
        hkrd_pkg::report_word_t word;
    } backlog_entry_t;

    // DUT-facing signals; the inputs are known from time zero
    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   cfg_we   = 1'b0;
    logic                   cfg_data = 1'b0;
    logic                   push     = 1'b0;
    logic                   full;
    hkrd_pkg::report_word_t report   = '0;
    logic                   empty;
    logic                   pop      = 1'b0;
    hkrd_pkg::event_word_t  key_event;

    // Stimulus and expectation stores
    backlog_entry_t        report_backlog [$];
    hkrd_pkg::event_word_t expected_events [$];

    // Bench copy of the decoder state
    logic [7:0] held_keys [hkrd_pkg::KEY_SLOT_COUNT];
    logic       model_event_mode = 1'b0;

    // Generator-side view of the last random report (typing continuity)
    logic [7:0] typed_keys [hkrd_pkg::KEY_SLOT_COUNT];

    // Handshake bookkeeping and statistics
    logic took          = 1'b0;  // current report taken at the last rising edge
    logic steady        = 1'b0;  // window with no idling on either side
    int   quiet_cycles  = 0;
    int   stall_left    = 0;
    int   cycle_count   = 0;
    int   reports_taken = 0;
    int   mode_writes   = 0;
    int   words_checked = 0;
    int   press_words   = 0;
    int   release_words = 0;
    int   mismatch_count = 0;
    logic timed_out     = 1'b0;

    always #5 clk = ~clk;

    hid_keyboard_report_decoder_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .report    (report),
        .empty     (empty),
        .pop       (pop),
        .key_event (key_event)
    );

    // ------------------------------------------------------------------
    // US layout character of a key usage code; 0 when the key has none.
    // ------------------------------------------------------------------
    function automatic logic [6:0] us_key_char(input logic [7:0] code, input logic shifted);
        string digits_plain = "1234567890";
        string digits_shift = "!@#$%^&*()";
        // Codes 45..56; position 5 (non-US hash) is never looked up.
        string punct_plain  = "-=[]\\ ;'`,./";
        string punct_shift  = "_+{}| :\"~<>?";
        if (code >= 8'd4 && code <= 8'd29)
        begin
            return 7'((shifted ? 8'h41 : 8'h61) + code - 8'd4);
        end
        if (code >= 8'd30 && code <= 8'd39)
        begin
            return shifted ? 7'(digits_shift[code - 30]) : 7'(digits_plain[code - 30]);
        end
        case (code)
            8'd40: return 7'h0A;   // enter
            8'd41: return 7'h1B;   // escape
            8'd42: return 7'h7F;   // backspace as DEL
            8'd43: return 7'h09;   // tab
            8'd44: return 7'h20;   // space
            8'd50: return 7'h00;   // non-US hash: no character
            default: ;
        endcase
        if (code >= 8'd45 && code <= 8'd56)
        begin
            return shifted ? 7'(punct_shift[code - 45]) : 7'(punct_plain[code - 45]);
        end
        return 7'h00;
    endfunction

    function automatic logic slot_present(input logic [7:0] slots [hkrd_pkg::KEY_SLOT_COUNT],
                                          input logic [7:0] code);
        for (int i = 0; i < hkrd_pkg::KEY_SLOT_COUNT; i++)
        begin
            if (slots[i] == code)
            begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Decode one accepted report: releases of held keys that are gone
    // (event mode only), then presses of keys that are new, in slot order.
    // The final word of the report carries last. Slots are then held.
    // ------------------------------------------------------------------
    function automatic void decode_report(input hkrd_pkg::report_word_t word);
        logic [7:0]            now_keys [hkrd_pkg::KEY_SLOT_COUNT];
        hkrd_pkg::event_word_t batch [hkrd_pkg::EVENT_COUNT];
        logic [6:0]            ch;
        logic                  shifted;
        int                    count;
        now_keys[0] = word.key_0;
        now_keys[1] = word.key_1;
        now_keys[2] = word.key_2;
        now_keys[3] = word.key_3;
        now_keys[4] = word.key_4;
        now_keys[5] = word.key_5;
        shifted = (word.modifiers & (hkrd_pkg::SHIFT_LEFT_BIT |
                                     hkrd_pkg::SHIFT_RIGHT_BIT)) != 8'h00;
        count = 0;
        if (model_event_mode)
        begin
            for (int i = 0; i < hkrd_pkg::KEY_SLOT_COUNT; i++)
            begin
                if (held_keys[i] >= hkrd_pkg::FIRST_KEY_CODE &&
                    !slot_present(now_keys, held_keys[i]))
                begin
                    batch[count] = '{event_kind: hkrd_pkg::EVENT_RELEASE,
                                     key_code: held_keys[i], ascii_char: 7'h00,
                                     modifier_bits: word.modifiers, last: 1'b0};
                    count++;
                end
            end
        end
        for (int i = 0; i < hkrd_pkg::KEY_SLOT_COUNT; i++)
        begin
            if (now_keys[i] >= hkrd_pkg::FIRST_KEY_CODE &&
                !slot_present(held_keys, now_keys[i]))
            begin
                ch = us_key_char(now_keys[i], shifted);
                // character mode drops presses with no character
                if (model_event_mode || ch != 7'h00)
                begin
                    batch[count] = '{event_kind: hkrd_pkg::EVENT_PRESS,
                                     key_code: now_keys[i], ascii_char: ch,
                                     modifier_bits: word.modifiers, last: 1'b0};
                    count++;
                end
            end
        end
        for (int i = 0; i < count; i++)
        begin
            batch[i].last = (i == count - 1);
            expected_events.push_back(batch[i]);
        end
        held_keys = now_keys;
    endfunction

    // One line per mismatch; the count keeps going past the print cap.
    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("mismatch at word %0d, %s: got %0h, want %0h",
                     words_checked, what, got, want);
        end
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Backlog builders
    // ------------------------------------------------------------------
    task automatic add_report(input logic [7:0] mods, input logic [7:0] k0, input logic [7:0] k1,
                              input logic [7:0] k2, input logic [7:0] k3, input logic [7:0] k4,
                              input logic [7:0] k5);
        backlog_entry_t entry;
        entry.kind = KIND_REPORT;
        entry.mode = 1'b0;
        entry.word = '{modifiers: mods, key_0: k0, key_1: k1, key_2: k2,
                       key_3: k3, key_4: k4, key_5: k5};
        report_backlog.push_back(entry);
    endtask

    task automatic add_mode(input logic mode);
        backlog_entry_t entry;
        entry.kind = KIND_MODE;
        entry.mode = mode;
        entry.word = '0;
        report_backlog.push_back(entry);
    endtask

    task automatic add_settle();
        backlog_entry_t entry;
        entry.kind = KIND_SETTLE;
        entry.mode = 1'b0;
        entry.word = '0;
        report_backlog.push_back(entry);
    endtask

    // Typing-like report: many slots stay held, some change to codes 4..56,
    // some clear or take codes 0..3, a few take any code or copy another slot.
    task automatic add_typed_report();
        logic [7:0] mods;
        logic [7:0] spare;
        int         pick;
        for (int i = 0; i < hkrd_pkg::KEY_SLOT_COUNT; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                ;
            else if (pick < 72)
                typed_keys[i] = 8'($urandom_range(4, 56));
            else if (pick < 82)
                typed_keys[i] = 8'h00;
            else if (pick < 87)
                typed_keys[i] = 8'($urandom_range(0, 3));
            else if (pick < 95)
                typed_keys[i] = 8'($urandom_range(0, 255));
            else
                typed_keys[i] = typed_keys[$urandom_range(0, hkrd_pkg::KEY_SLOT_COUNT - 1)];
        end
        // now and then the same keys move to other slots
        if ($urandom_range(0, 19) == 0)
        begin
            spare = typed_keys[0];
            for (int i = 0; i < hkrd_pkg::KEY_SLOT_COUNT - 1; i++)
            begin
                typed_keys[i] = typed_keys[i + 1];
            end
            typed_keys[hkrd_pkg::KEY_SLOT_COUNT - 1] = spare;
        end
        pick = $urandom_range(0, 99);
        if (pick < 30)
            mods = 8'h00;
        else if (pick < 40)
            mods = hkrd_pkg::SHIFT_LEFT_BIT;
        else if (pick < 50)
            mods = hkrd_pkg::SHIFT_RIGHT_BIT;
        else if (pick < 55)
            mods = hkrd_pkg::SHIFT_LEFT_BIT | hkrd_pkg::SHIFT_RIGHT_BIT;
        else
            mods = 8'($urandom_range(0, 255));
        add_report(mods, typed_keys[0], typed_keys[1], typed_keys[2],
                   typed_keys[3], typed_keys[4], typed_keys[5]);
    endtask

    // ------------------------------------------------------------------
    // Rising edge: take inputs and outputs as the block sees them.
    // Prediction runs before the output check; a report's words cannot
    // show up in the cycle it is taken.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                model_event_mode = cfg_data;
                mode_writes++;
            end
            if (push && !full)
            begin
                decode_report(report);
                reports_taken++;
                took = 1'b1;
            end
            if (pop && !empty)
            begin
                if (expected_events.size() == 0)
                begin
                    flag_mismatch("word with nothing due", 32'(key_event), 32'h0);
                end
                else
                begin
                    if (key_event.event_kind !== expected_events[0].event_kind)
                        flag_mismatch("event_kind", 32'(key_event.event_kind),
                                      32'(expected_events[0].event_kind));
                    if (key_event.key_code !== expected_events[0].key_code)
                        flag_mismatch("key_code", 32'(key_event.key_code),
                                      32'(expected_events[0].key_code));
                    if (key_event.ascii_char !== expected_events[0].ascii_char)
                        flag_mismatch("ascii_char", 32'(key_event.ascii_char),
                                      32'(expected_events[0].ascii_char));
                    if (key_event.modifier_bits !== expected_events[0].modifier_bits)
                        flag_mismatch("modifier_bits", 32'(key_event.modifier_bits),
                                      32'(expected_events[0].modifier_bits));
                    if (key_event.last !== expected_events[0].last)
                        flag_mismatch("last", 32'(key_event.last),
                                      32'(expected_events[0].last));
                    if (expected_events[0].event_kind == hkrd_pkg::EVENT_PRESS)
                        press_words++;
                    else
                        release_words++;
                    void'(expected_events.pop_front());
                end
                words_checked++;
            end
            // Idle means nothing due, nothing offered, no write in flight.
            if (expected_events.size() == 0 && !push && !cfg_we)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            steady = (reports_taken >= 150 && reports_taken < 260);
        end
    end

    // ------------------------------------------------------------------
    // Report driver, falling edge. A report offered stays on the port
    // until taken. Mode writes and settle pauses wait for a quiet block.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        backlog_entry_t head;
        logic           push_next;
        logic           we_next;
        if (rst_n)
        begin
            push_next = 1'b0;
            we_next   = 1'b0;
            if (push && !took)
            begin
                push_next = 1'b1;
            end
            else
            begin
                took = 1'b0;
                if (report_backlog.size() != 0)
                begin
                    head = report_backlog[0];
                    case (head.kind)
                        KIND_REPORT:
                        begin
                            if (steady || $urandom_range(0, 99) >= IDLE_PCT)
                            begin
                                report    <= head.word;
                                push_next  = 1'b1;
                                void'(report_backlog.pop_front());
                            end
                        end
                        KIND_MODE:
                        begin
                            if (quiet_cycles >= SETTLE_CYCLES)
                            begin
                                cfg_data <= head.mode;
                                we_next   = 1'b1;
                                void'(report_backlog.pop_front());
                            end
                        end
                        default:
                        begin
                            if (quiet_cycles >= SETTLE_CYCLES)
                                void'(report_backlog.pop_front());
                        end
                    endcase
                end
            end
            push   <= push_next;
            cfg_we <= we_next;
        end
    end

    // ------------------------------------------------------------------
    // Word taker, falling edge: random idling plus rare long stalls that
    // back the job queue up until full rises.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        logic pop_next;
        if (stall_left != 0)
        begin
            stall_left--;
            pop_next = 1'b0;
        end
        else if (steady)
        begin
            pop_next = 1'b1;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_left = $urandom_range(10, 40);
            pop_next = ($urandom_range(0, 99) >= IDLE_PCT);
        end
        pop <= pop_next;
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < hkrd_pkg::KEY_SLOT_COUNT; i++)
        begin
            held_keys[i]  = 8'h00;
            typed_keys[i] = 8'h00;
        end

        // Event mode, directed corners
        add_mode(1'b1);
        add_report(8'h00,                     8'd4,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0);
        add_report(hkrd_pkg::SHIFT_LEFT_BIT,  8'd4,  8'd29, 8'd0,  8'd0,  8'd0,  8'd0);
        add_report(hkrd_pkg::SHIFT_RIGHT_BIT, 8'd30, 8'd31, 8'd32, 8'd33, 8'd34, 8'd35);
        add_report(8'h00,                     8'd36, 8'd37, 8'd38, 8'd39, 8'd1,  8'd2);
        add_report(8'hFF,                     8'd40, 8'd41, 8'd42, 8'd43, 8'd44, 8'd3);
        add_report(8'h00,                     8'd45, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50);
        add_report(hkrd_pkg::SHIFT_LEFT_BIT,  8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56);
        // six releases and six presses from one report
        add_report(8'h22,                     8'd45, 8'd46, 8'd47, 8'd48, 8'd49, 8'd50);
        // keys with no character still press in event mode
        add_report(8'h00,                     8'd57, 8'd100, 8'd255, 8'd254, 8'd128, 8'd224);
        // the same code in several slots repeats its event
        add_report(8'h00,                     8'd4,  8'd4,  8'd4,  8'd5,  8'd5,  8'd0);
        add_report(8'h00,                     8'd4,  8'd4,  8'd0,  8'd0,  8'd0,  8'd0);
        add_report(8'h00,                     8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0);
        // no change: no words at all
        add_report(8'h00,                     8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0);
        add_report(8'hFF,                     8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        // codes below four never make an event, but release what was held
        add_report(8'h00,                     8'd0,  8'd1,  8'd2,  8'd3,  8'd0,  8'd1);

        // Character mode, directed
        add_mode(1'b0);
        add_report(8'h00,                     8'd4,  8'd50, 8'd57, 8'd30, 8'd44, 8'd0);
        add_report(hkrd_pkg::SHIFT_RIGHT_BIT, 8'd4,  8'd50, 8'd57, 8'd30, 8'd44, 8'd53);
        add_report(8'h00,                     8'd50, 8'd57, 8'd58, 8'd0,  8'd0,  8'd0);
        add_report(8'hDD,                     8'd29, 8'd39, 8'd56, 8'd0,  8'd0,  8'd0);
        add_report(hkrd_pkg::SHIFT_LEFT_BIT,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0);
        add_report(hkrd_pkg::SHIFT_RIGHT_BIT, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25);

        // Random typing, alternating modes; one mid-phase full drain
        for (int phase = 0; phase < 4; phase++)
        begin
            add_mode(phase % 2 == 0);
            for (int n = 0; n < 102; n++)
            begin
                if (phase == 0 && n == 51)
                    add_settle();
                add_typed_report();
            end
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for the backlog to go out and every word to come back.
        while (report_backlog.size() != 0 || push || expected_events.size() != 0)
        begin
            @(posedge clk);
            if (cycle_count >= CYCLE_LIMIT)
            begin
                timed_out = 1'b1;
                break;
            end
        end

        if (!timed_out)
            repeat (TAIL_CYCLES) @(posedge clk);
        else
            $display("timeout after %0d cycles, %0d words still due",
                     cycle_count, expected_events.size());

        $display("ran %0d reports and %0d mode writes in %0d cycles",
                 reports_taken, mode_writes, cycle_count);
        $display("compared %0d key words (%0d presses, %0d releases), %0d mismatches",
                 words_checked, press_words, release_words, mismatch_count);
        if (!timed_out && mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
